[src/bcc_pkg.sv]
// ----------------------------------------------------------------------------
// Button click classifier package
// Shared widths, codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bcc_pkg;

  localparam int TIME_W     = 32;
  localparam int THRESH_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W    = 3;
  localparam int EVENT_W    = 2;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE     = 3'd0,
    PH_DEB1     = 3'd1,
    PH_PRESSED  = 3'd2,
    PH_WAIT2    = 3'd3,
    PH_DEB2     = 3'd4,
    PH_PRESSED2 = 3'd5,
    PH_LONG     = 3'd6
  } phase_t;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE     = 2'd0,
    REG_LONG_PRESS   = 2'd1,
    REG_DOUBLE_GAP   = 2'd2,
    REG_ACTIVE_LEVEL = 2'd3
  } cfg_reg_t;

  localparam logic [THRESH_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [THRESH_W-1:0] LONG_PRESS_RST = 16'd800;
  localparam logic [THRESH_W-1:0] DOUBLE_GAP_RST = 16'd250;
  localparam logic                ACTIVE_LVL_RST = 1'b0;

endpackage

[src/bcc_in_if.sv]
// ----------------------------------------------------------------------------
// Button poll channel
// Carries one request per poll: raw pin level and millisecond timestamp.
// ----------------------------------------------------------------------------
interface bcc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       pin_level;
  logic [bcc_pkg::TIME_W-1:0] now_ms;

  modport source (output valid, output pin_level, output now_ms, input ready);
  modport sink (input valid, input pin_level, input now_ms, output ready);
endinterface

[src/bcc_out_if.sv]
// ----------------------------------------------------------------------------
// Classifier result channel
// Carries one request per poll: the event code and the phase after the poll.
// ----------------------------------------------------------------------------
interface bcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [bcc_pkg::EVENT_W-1:0] event_res;
  logic [bcc_pkg::PHASE_W-1:0] phase;

  modport source (output valid, output event_res, output phase, input ready);
  modport sink (input valid, input event_res, input phase, output ready);
endinterface

[src/bcc_cfg_if.sv]
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries one register write request: register index and write data.
// ----------------------------------------------------------------------------
interface bcc_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bcc_pkg::CFG_IDX_W-1:0]  index;
  logic [bcc_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[src/button_click_classifier.sv]
// ----------------------------------------------------------------------------
// Button click classifier
// Debounces polled button samples and reports single, double and long presses.
// ----------------------------------------------------------------------------
// The block takes one poll per clock cycle while the result channel is not
// stalled and returns exactly one result per poll. A poll is first captured
// in an input register; once the result register is free, a single
// subtraction of the phase start time and three threshold compares update the
// phase state and load the result register, which drives the result channel.
// Elapsed time wraps modulo two to the 32. Registers should be written only
// while no request is in flight.
module button_click_classifier (
  input logic      clk,
  input logic      rst_n,
  bcc_in_if.sink   in_chan,
  bcc_out_if.source out_chan,
  bcc_cfg_if.sink  cfg_chan
);

  logic [bcc_pkg::THRESH_W-1:0] debounce_r;
  logic [bcc_pkg::THRESH_W-1:0] long_press_r;
  logic [bcc_pkg::THRESH_W-1:0] double_gap_r;
  logic                         active_level_r;

  logic                         s1_valid_r;
  logic                         s1_pin_r;
  logic [bcc_pkg::TIME_W-1:0]   s1_now_r;

  bcc_pkg::phase_t              phase_r;
  bcc_pkg::phase_t              phase_nxt;
  logic [bcc_pkg::TIME_W-1:0]   phase_start_r;
  logic [bcc_pkg::TIME_W-1:0]   phase_start_nxt;
  logic                         one_click_r;
  logic                         one_click_nxt;
  bcc_pkg::event_t              event_nxt;

  logic                         out_valid_r;
  bcc_pkg::event_t              out_event_r;
  bcc_pkg::phase_t              out_phase_r;

  logic                         out_free;
  logic                         s1_fire;
  logic                         pressed;
  logic [bcc_pkg::TIME_W-1:0]   elapsed;
  logic                         deb_done;
  logic                         long_done;
  logic                         gap_done;

  assign out_free      = !out_valid_r || out_chan.ready;
  assign s1_fire       = s1_valid_r && out_free;
  assign in_chan.ready = !s1_valid_r || out_free;
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid     = out_valid_r;
  assign out_chan.event_res = out_event_r;
  assign out_chan.phase     = out_phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r     <= bcc_pkg::DEBOUNCE_RST;
      long_press_r   <= bcc_pkg::LONG_PRESS_RST;
      double_gap_r   <= bcc_pkg::DOUBLE_GAP_RST;
      active_level_r <= bcc_pkg::ACTIVE_LVL_RST;
    end else if (cfg_chan.valid) begin
      case (bcc_pkg::cfg_reg_t'(cfg_chan.index))
        bcc_pkg::REG_DEBOUNCE:     debounce_r     <= cfg_chan.data;
        bcc_pkg::REG_LONG_PRESS:   long_press_r   <= cfg_chan.data;
        bcc_pkg::REG_DOUBLE_GAP:   double_gap_r   <= cfg_chan.data;
        bcc_pkg::REG_ACTIVE_LEVEL: active_level_r <= cfg_chan.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      s1_pin_r <= in_chan.pin_level;
      s1_now_r <= in_chan.now_ms;
    end
  end

  assign pressed   = (s1_pin_r == active_level_r);
  assign elapsed   = s1_now_r - phase_start_r;
  assign deb_done  = elapsed >= bcc_pkg::TIME_W'(debounce_r);
  assign long_done = elapsed >= bcc_pkg::TIME_W'(long_press_r);
  assign gap_done  = elapsed >= bcc_pkg::TIME_W'(double_gap_r);

  always_comb begin
    phase_nxt       = phase_r;
    phase_start_nxt = phase_start_r;
    one_click_nxt   = one_click_r;
    event_nxt       = bcc_pkg::EV_NONE;
    case (phase_r)
      bcc_pkg::PH_IDLE: begin
        if (pressed) begin
          phase_nxt       = bcc_pkg::PH_DEB1;
          phase_start_nxt = s1_now_r;
        end
      end
      bcc_pkg::PH_DEB1: begin
        if (!pressed) begin
          phase_nxt = bcc_pkg::PH_IDLE;
        end else if (deb_done) begin
          phase_nxt       = bcc_pkg::PH_PRESSED;
          phase_start_nxt = s1_now_r;
        end
      end
      bcc_pkg::PH_PRESSED: begin
        if (!pressed) begin
          if (long_done) begin
            event_nxt = bcc_pkg::EV_LONG;
            phase_nxt = bcc_pkg::PH_IDLE;
          end else begin
            one_click_nxt   = 1'b1;
            phase_nxt       = bcc_pkg::PH_WAIT2;
            phase_start_nxt = s1_now_r;
          end
        end else if (long_done) begin
          event_nxt = bcc_pkg::EV_LONG;
          phase_nxt = bcc_pkg::PH_LONG;
        end
      end
      bcc_pkg::PH_LONG: begin
        if (!pressed) begin
          phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
      bcc_pkg::PH_WAIT2: begin
        if (pressed) begin
          phase_nxt       = bcc_pkg::PH_DEB2;
          phase_start_nxt = s1_now_r;
        end else if (gap_done) begin
          if (one_click_r) begin
            event_nxt = bcc_pkg::EV_SINGLE;
          end
          phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
      bcc_pkg::PH_DEB2: begin
        if (!pressed) begin
          phase_nxt = bcc_pkg::PH_WAIT2;
        end else if (deb_done) begin
          phase_nxt       = bcc_pkg::PH_PRESSED2;
          phase_start_nxt = s1_now_r;
        end
      end
      bcc_pkg::PH_PRESSED2: begin
        if (!pressed) begin
          event_nxt = bcc_pkg::EV_DOUBLE;
          phase_nxt = bcc_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_nxt = bcc_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= bcc_pkg::PH_IDLE;
      phase_start_r <= '0;
      one_click_r   <= 1'b0;
    end else if (s1_fire) begin
      phase_r       <= phase_nxt;
      phase_start_r <= phase_start_nxt;
      one_click_r   <= one_click_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event_r <= event_nxt;
      out_phase_r <= phase_nxt;
    end
  end

  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("accepted poll did not reach the result register");

  a_long_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_event_r == bcc_pkg::EV_LONG |->
      out_phase_r == bcc_pkg::PH_LONG || out_phase_r == bcc_pkg::PH_IDLE)
    else $error("long press reported with wrong phase");

  a_click_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_event_r == bcc_pkg::EV_SINGLE ||
      out_event_r == bcc_pkg::EV_DOUBLE) |-> out_phase_r == bcc_pkg::PH_IDLE)
    else $error("click reported without return to idle");

  a_click_flag_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(one_click_r))
    else $error("click flag cleared without reset");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_phase_r == phase_r)
    else $error("result phase differs from phase state");

endmodule
